// ----- rtl/peer_group_window_filter_core_macros.svh -----
// Assertion macros shared by the checker of the peer group window filter.
`ifndef PEER_GROUP_WINDOW_FILTER_CORE_MACROS_SVH
`define PEER_GROUP_WINDOW_FILTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PGWF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peer group filter check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PGWF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peer group filter check failed");

`endif

// ----- rtl/pgwf_pkg.sv -----
// Shared types, widths and register codes of the peer group window filter.
package pgwf_pkg;

  localparam int BLOCK_DEFAULT = 3;
  localparam int NMAX = 25;   // largest window, 5 x 5
  localparam int PW   = 5;    // position and count width
  localparam int SW   = 13;   // sum of differences
  localparam int QW   = 21;   // sum of squared differences
  localparam int AW   = 27;   // group scatter terms
  localparam int NNW  = 18;   // mean difference term
  localparam int DDW  = 31;   // combined scatter
  localparam int DENW = 39;   // discriminant denominator
  localparam int NUMW = 36;   // discriminant numerator
  localparam int CSW  = 29;   // weighted pixel sum
  localparam int WSW  = 21;   // weight sum
  localparam int NDW  = 30;   // dividend of the rounded mean
  localparam int DW   = 22;   // divisor of the rounded mean

  localparam logic [7:0]  ALPHA_RESET    = 8'd16;
  localparam logic [7:0]  ALPHA_FALLBACK = 8'd16;
  localparam logic [15:0] W0_RESET = 16'd65535;
  localparam logic [15:0] W1_RESET = 16'd39749;
  localparam logic [15:0] W2_RESET = 16'd24109;
  localparam logic [15:0] W4_RESET = 16'd8869;
  localparam logic [15:0] W5_RESET = 16'd5379;
  localparam logic [15:0] W8_RESET = 16'd1200;

  typedef enum logic [2:0] {
    CFG_ALPHA = 3'd0,
    CFG_W0    = 3'd1,
    CFG_W1    = 3'd2,
    CFG_W2    = 3'd3,
    CFG_W4    = 3'd4,
    CFG_W5    = 3'd5,
    CFG_W8    = 3'd6
  } cfg_idx_t;

  // Window context handed from split cell to split cell.
  typedef struct packed {
    logic [NMAX-1:0][7:0]    pix;
    logic [NMAX-1:0][7:0]    d;
    logic [NMAX-1:0][PW-1:0] pos;
    logic [SW-1:0]           stot;
    logic [QW-1:0]           qtot;
    logic [SW-1:0]           s1;
    logic [QW-1:0]           q1;
    logic [PW-1:0]           best;
    logic [NUMW-1:0]         bnum;
    logic [DENW-1:0]         bden;
  } ctx_t;

  // Partial quotient and result fields handed along the divider cells.
  typedef struct packed {
    logic [NDW-1:0] rem;
    logic [DW-1:0]  dvs;
    logic [7:0]     quo;
    logic [7:0]     center;
    logic           wzero;
    logic [PW-1:0]  count;
    logic           imp;
  } div_t;

endpackage

// ----- rtl/pgwf_split_cell.sv -----
// One split cell: scores split K of the sorted differences and keeps the best.
module pgwf_split_cell #(
  parameter int N = pgwf_pkg::BLOCK_DEFAULT * pgwf_pkg::BLOCK_DEFAULT,
  parameter int K = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  pgwf_pkg::ctx_t  in_ctx,
  output logic            out_valid,
  output pgwf_pkg::ctx_t  out_ctx
);

  localparam int R   = N - K;
  localparam int KR  = K * R;
  localparam int LOW = 20;
  localparam int HI  = pgwf_pkg::DENW - LOW;
  localparam int PRW = pgwf_pkg::NUMW + pgwf_pkg::DENW;

  logic [5:0] v_r;
  pgwf_pkg::ctx_t ca_r, cb_r, cc_r, cd_r, ce_r, cf_r;

  logic [pgwf_pkg::AW-1:0]   kq1_r, s1sq_r, rq2_r, s2sq_r;
  logic [pgwf_pkg::NNW-1:0]  s1r_r, s2k_r;
  logic [pgwf_pkg::DDW-1:0]  ar_r, bk_r;
  logic [pgwf_pkg::NUMW-1:0] num_c_r, num_d_r;
  logic [pgwf_pkg::DENW-1:0] den_r;
  logic [pgwf_pkg::NUMW+LOW-1:0] p1l_r, p2l_r;
  logic [pgwf_pkg::NUMW+HI-1:0]  p1h_r, p2h_r;
  logic [pgwf_pkg::NUMW-1:0] num_e_r;
  logic [pgwf_pkg::DENW-1:0] den_e_r;

  logic [7:0] dk;
  logic [pgwf_pkg::SW-1:0] s2;
  logic [pgwf_pkg::QW-1:0] q2;
  logic [pgwf_pkg::AW-1:0] a_sc, b_sc;
  logic [pgwf_pkg::NNW-1:0] nn;
  logic [pgwf_pkg::DDW-1:0] dd;
  logic [PRW-1:0] p1, p2;
  logic take;

  assign dk   = in_ctx.d[K-1];
  assign s2   = ca_r.stot - ca_r.s1;
  assign q2   = ca_r.qtot - ca_r.q1;
  assign a_sc = kq1_r - s1sq_r;
  assign b_sc = rq2_r - s2sq_r;
  assign nn   = (s1r_r >= s2k_r) ? (s1r_r - s2k_r) : (s2k_r - s1r_r);
  assign dd   = ar_r + bk_r;
  assign p1   = (PRW'(p1h_r) << LOW) + PRW'(p1l_r);
  assign p2   = (PRW'(p2h_r) << LOW) + PRW'(p2l_r);
  assign take = (K == 1) || (p1 >= p2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Add the next sorted difference to the head group.
      ca_r    <= in_ctx;
      ca_r.s1 <= in_ctx.s1 + pgwf_pkg::SW'(dk);
      ca_r.q1 <= in_ctx.q1 + pgwf_pkg::QW'(dk * dk);
      // Products of group counts and sums.
      cb_r   <= ca_r;
      kq1_r  <= pgwf_pkg::AW'(K) * pgwf_pkg::AW'(ca_r.q1);
      s1sq_r <= pgwf_pkg::AW'(ca_r.s1) * pgwf_pkg::AW'(ca_r.s1);
      rq2_r  <= pgwf_pkg::AW'(R) * pgwf_pkg::AW'(q2);
      s2sq_r <= pgwf_pkg::AW'(s2) * pgwf_pkg::AW'(s2);
      s1r_r  <= pgwf_pkg::NNW'(ca_r.s1) * pgwf_pkg::NNW'(R);
      s2k_r  <= pgwf_pkg::NNW'(s2) * pgwf_pkg::NNW'(K);
      // Scatters weighted by the other group's count, and squared mean gap.
      cc_r    <= cb_r;
      ar_r    <= pgwf_pkg::DDW'(a_sc) * pgwf_pkg::DDW'(R);
      bk_r    <= pgwf_pkg::DDW'(b_sc) * pgwf_pkg::DDW'(K);
      num_c_r <= pgwf_pkg::NUMW'(nn) * pgwf_pkg::NUMW'(nn);
      // Denominator; a zero scatter counts as K*R.
      cd_r    <= cc_r;
      num_d_r <= num_c_r;
      den_r   <= (dd != '0) ? pgwf_pkg::DENW'(KR) * pgwf_pkg::DENW'(dd)
                            : pgwf_pkg::DENW'(KR * KR);
      // Cross products in halves.
      ce_r    <= cd_r;
      num_e_r <= num_d_r;
      den_e_r <= den_r;
      p1l_r   <= (pgwf_pkg::NUMW+LOW)'(num_d_r) * (pgwf_pkg::NUMW+LOW)'(cd_r.bden[LOW-1:0]);
      p1h_r   <= (pgwf_pkg::NUMW+HI)'(num_d_r) *
                 (pgwf_pkg::NUMW+HI)'(cd_r.bden[pgwf_pkg::DENW-1:LOW]);
      p2l_r   <= (pgwf_pkg::NUMW+LOW)'(cd_r.bnum) * (pgwf_pkg::NUMW+LOW)'(den_r[LOW-1:0]);
      p2h_r   <= (pgwf_pkg::NUMW+HI)'(cd_r.bnum) *
                 (pgwf_pkg::NUMW+HI)'(den_r[pgwf_pkg::DENW-1:LOW]);
      // Later splits win ties.
      cf_r <= ce_r;
      if (take) begin
        cf_r.bnum <= num_e_r;
        cf_r.bden <= den_e_r;
        cf_r.best <= pgwf_pkg::PW'(K);
      end
    end
  end

  assign out_valid = v_r[5];
  assign out_ctx   = cf_r;

endmodule

// ----- rtl/pgwf_div_cell.sv -----
// One divider cell: settles one quotient bit of the rounded weighted mean.
module pgwf_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pgwf_pkg::div_t in_div,
  output logic           out_valid,
  output pgwf_pkg::div_t out_div
);

  logic valid_r;
  pgwf_pkg::div_t div_r;
  logic [pgwf_pkg::NDW-1:0] sub;

  assign sub = pgwf_pkg::NDW'(in_div.dvs) << BIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= in_div;
      if (in_div.rem >= sub) begin
        div_r.rem      <= in_div.rem - sub;
        div_r.quo[BIT] <= 1'b1;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_div   = div_r;

endmodule

// ----- rtl/peer_group_window_filter_core.sv -----
// Top level of the peer group window filter: sort, split chain, mean and divider.
//
// One input word carries a whole BLOCK x BLOCK window of 8-bit pixels in raster
// order, pixel 0 in the lowest byte of in_tdata. One output word follows for
// each window: the filtered pixel, the size of the peer group, and in out_tuser
// a flag that is set when the impulse gap rule picked the tail group.
// The block accepts one window per clock cycle when the receiver keeps up.
// A window passes in order through difference, rank and sort, the BLOCK*BLOCK-1
// split cells of the chain, group selection and weighted sums, eight divider
// cells, and the output register.
// The whole pipeline moves on one enable: while out_tvalid is high and
// out_tready is low everything holds, in_tready drops and no word is lost.
// The configuration channel is always ready and writes alpha (index 0) and the
// six Gaussian weights (index 1 to 6); index 7 is ignored. Writes are meant
// for an idle block. A synchronous reset clears the pipeline valid bits and
// loads the default registers; no clearing pass is needed.
module peer_group_window_filter_core #(
  parameter int BLOCK = pgwf_pkg::BLOCK_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pixels_a [63:0], pixels_b [127:64], pixels_c [191:128], pixel_last [199:192]
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // filtered_pixel [7:0], peer_count [12:8], zero fill [15:13]
  output logic [15:0]  out_tdata,
  // impulse_seen [0]
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int N      = BLOCK * BLOCK;
  localparam int HALF   = BLOCK / 2;
  localparam int CENTER = HALF * BLOCK + HALF;
  localparam int NG     = (N + 4) / 5;
  localparam int NMAX   = pgwf_pkg::NMAX;
  localparam int PW     = pgwf_pkg::PW;

  // Configuration registers.
  logic [7:0]  alpha_r;
  logic [15:0] w0_r, w1_r, w2_r, w4_r, w5_r, w8_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= pgwf_pkg::ALPHA_RESET;
      w0_r    <= pgwf_pkg::W0_RESET;
      w1_r    <= pgwf_pkg::W1_RESET;
      w2_r    <= pgwf_pkg::W2_RESET;
      w4_r    <= pgwf_pkg::W4_RESET;
      w5_r    <= pgwf_pkg::W5_RESET;
      w8_r    <= pgwf_pkg::W8_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pgwf_pkg::CFG_ALPHA: alpha_r <= cfg_data[7:0];
        pgwf_pkg::CFG_W0:    w0_r    <= cfg_data;
        pgwf_pkg::CFG_W1:    w1_r    <= cfg_data;
        pgwf_pkg::CFG_W2:    w2_r    <= cfg_data;
        pgwf_pkg::CFG_W4:    w4_r    <= cfg_data;
        pgwf_pkg::CFG_W5:    w5_r    <= cfg_data;
        pgwf_pkg::CFG_W8:    w8_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Weight of each window position, chosen by its squared radius.
  logic [NMAX-1:0][15:0] wpos;

  for (genvar p = 0; p < NMAX; p++) begin : g_wpos
    if (p < N) begin : g_used
      localparam int DY = p / BLOCK - HALF;
      localparam int DX = p % BLOCK - HALF;
      localparam int R2 = DY * DY + DX * DX;
      if (R2 == 0)      begin : g_r0 assign wpos[p] = w0_r; end
      else if (R2 == 1) begin : g_r1 assign wpos[p] = w1_r; end
      else if (R2 == 2) begin : g_r2 assign wpos[p] = w2_r; end
      else if (R2 == 4) begin : g_r4 assign wpos[p] = w4_r; end
      else if (R2 == 5) begin : g_r5 assign wpos[p] = w5_r; end
      else if (R2 == 8) begin : g_r8 assign wpos[p] = w8_r; end
      else              begin : g_rx assign wpos[p] = '0;   end
    end else begin : g_unused
      assign wpos[p] = '0;
    end
  end

  // The whole pipeline advances together unless a result is held.
  logic en;
  logic out_valid_r;

  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  // Stage 0: unpack pixels and take differences to the center.
  logic s0_v_r;
  logic [NMAX-1:0][7:0] s0_pix_r, s0_d_r;
  logic [NMAX-1:0][7:0] pix_in, d_in;

  always_comb begin
    pix_in = '0;
    d_in   = '0;
    for (int i = 0; i < N; i++) begin
      pix_in[i] = in_tdata[8*i +: 8];
    end
    for (int i = 0; i < N; i++) begin
      d_in[i] = (pix_in[i] > pix_in[CENTER]) ? (pix_in[i] - pix_in[CENTER])
                                             : (pix_in[CENTER] - pix_in[i]);
    end
  end

  // Stage 1: ordering matrix and group sums; stage 2: ranks and totals.
  logic s1_v_r, s2_v_r, s3_v_r;
  logic [NMAX-1:0][7:0] s1_pix_r, s1_d_r, s2_pix_r, s2_d_r;
  logic [NMAX-1:0][NMAX-1:0] lt_nxt, lt_r;
  logic [NG-1:0][pgwf_pkg::SW-1:0] gs_nxt, gs_r;
  logic [NG-1:0][pgwf_pkg::QW-1:0] gq_nxt, gq_r;
  logic [NMAX-1:0][PW-1:0] rank_nxt, rank_r;
  logic [pgwf_pkg::SW-1:0] stot_nxt, stot_r;
  logic [pgwf_pkg::QW-1:0] qtot_nxt, qtot_r;

  always_comb begin
    lt_nxt = '0;
    gs_nxt = '0;
    gq_nxt = '0;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        // Stable order: smaller difference, or equal and earlier in raster.
        lt_nxt[i][j] = (s0_d_r[j] < s0_d_r[i]) || ((s0_d_r[j] == s0_d_r[i]) && (j < i));
      end
    end
    for (int g = 0; g < NG; g++) begin
      for (int m = 0; m < 5; m++) begin
        if (g * 5 + m < N) begin
          gs_nxt[g] = gs_nxt[g] + pgwf_pkg::SW'(s0_d_r[g*5+m]);
          gq_nxt[g] = gq_nxt[g] + pgwf_pkg::QW'(s0_d_r[g*5+m] * s0_d_r[g*5+m]);
        end
      end
    end
  end

  always_comb begin
    rank_nxt = '0;
    stot_nxt = '0;
    qtot_nxt = '0;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        rank_nxt[i] = rank_nxt[i] + PW'(lt_r[i][j]);
      end
    end
    for (int g = 0; g < NG; g++) begin
      stot_nxt = stot_nxt + gs_r[g];
      qtot_nxt = qtot_nxt + gq_r[g];
    end
  end

  // Stage 3: place every difference at its rank and seed the split chain.
  pgwf_pkg::ctx_t ctx_nxt;

  always_comb begin
    ctx_nxt      = '0;
    ctx_nxt.pix  = s2_pix_r;
    ctx_nxt.stot = stot_r;
    ctx_nxt.qtot = qtot_r;
    ctx_nxt.best = PW'(1);
    ctx_nxt.bden = pgwf_pkg::DENW'(1);
    for (int r = 0; r < N; r++) begin
      for (int i = 0; i < N; i++) begin
        if (rank_r[i] == PW'(r)) begin
          ctx_nxt.d[r]   = ctx_nxt.d[r] | s2_d_r[i];
          ctx_nxt.pos[r] = ctx_nxt.pos[r] | PW'(i);
        end
      end
    end
  end

  pgwf_pkg::ctx_t s3_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pix_r <= pix_in;
      s0_d_r   <= d_in;
      s1_pix_r <= s0_pix_r;
      s1_d_r   <= s0_d_r;
      lt_r     <= lt_nxt;
      gs_r     <= gs_nxt;
      gq_r     <= gq_nxt;
      s2_pix_r <= s1_pix_r;
      s2_d_r   <= s1_d_r;
      rank_r   <= rank_nxt;
      stot_r   <= stot_nxt;
      qtot_r   <= qtot_nxt;
      s3_ctx_r <= ctx_nxt;
    end
  end

  // Chain of split cells, one for each split of the sorted differences.
  logic           cv [N];
  pgwf_pkg::ctx_t cx [N];

  assign cv[0] = s3_v_r;
  assign cx[0] = s3_ctx_r;

  for (genvar k = 1; k < N; k++) begin : g_split
    pgwf_split_cell #(
      .N (N),
      .K (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[k-1]),
      .in_ctx    (cx[k-1]),
      .out_valid (cv[k]),
      .out_ctx   (cx[k])
    );
  end

  // Group selection: impulse gap test, or the head group of the best split.
  pgwf_pkg::ctx_t fin;
  logic [7:0]    thr;
  logic          mark_v;
  logic [PW-1:0] mark;
  logic          imp_nxt;
  logic [NMAX-1:0] mask_nxt;
  logic [PW-1:0] count_nxt;

  assign fin = cx[N-1];
  assign thr = (alpha_r != '0) ? alpha_r : pgwf_pkg::ALPHA_FALLBACK;

  always_comb begin
    mark_v = 1'b0;
    mark   = '0;
    for (int i = 0; i < HALF; i++) begin
      if ((fin.d[i+1] - fin.d[i]) > thr) begin
        mark_v = 1'b1;
        mark   = PW'(i);
      end
    end
    if ((fin.d[N-1] - fin.d[N-2]) > thr) begin
      mark_v = 1'b1;
      mark   = PW'(N - 2);
    end
    imp_nxt  = (fin.best <= PW'(HALF)) && mark_v && (mark < PW'(HALF + 2));
    mask_nxt = '0;
    for (int i = 0; i < N; i++) begin
      mask_nxt[i] = imp_nxt ? (PW'(i) > mark) : (PW'(i) < fin.best);
    end
    count_nxt = imp_nxt ? (PW'(N - 1) - mark) : fin.best;
  end

  logic m_v_r, w1_v_r, w2_v_r, w3_v_r;
  logic [NMAX-1:0] mask_r;
  logic [NMAX-1:0][7:0] m_pix_r;
  logic [NMAX-1:0][PW-1:0] m_pos_r;
  logic [PW-1:0] m_count_r, w1_count_r, w2_count_r, w3_count_r;
  logic m_imp_r, w1_imp_r, w2_imp_r, w3_imp_r;
  logic [7:0] m_center_r, w1_center_r, w2_center_r, w3_center_r;

  // Weighted terms of the peer group, then a two-level sum.
  logic [NMAX-1:0][23:0] prod_nxt, prod_r;
  logic [NMAX-1:0][15:0] wt_nxt, wt_r;
  logic [NG-1:0][pgwf_pkg::CSW-1:0] csg_nxt, csg_r;
  logic [NG-1:0][pgwf_pkg::WSW-1:0] wsg_nxt, wsg_r;
  logic [pgwf_pkg::CSW-1:0] csum_nxt, csum_r;
  logic [pgwf_pkg::WSW-1:0] wsum_nxt, wsum_r;

  always_comb begin
    prod_nxt = '0;
    wt_nxt   = '0;
    for (int i = 0; i < N; i++) begin
      if (mask_r[i]) begin
        wt_nxt[i]   = wpos[m_pos_r[i]];
        prod_nxt[i] = 24'(wpos[m_pos_r[i]]) * 24'(m_pix_r[m_pos_r[i]]);
      end
    end
  end

  always_comb begin
    csg_nxt = '0;
    wsg_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      for (int m = 0; m < 5; m++) begin
        if (g * 5 + m < N) begin
          csg_nxt[g] = csg_nxt[g] + pgwf_pkg::CSW'(prod_r[g*5+m]);
          wsg_nxt[g] = wsg_nxt[g] + pgwf_pkg::WSW'(wt_r[g*5+m]);
        end
      end
    end
    csum_nxt = '0;
    wsum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      csum_nxt = csum_nxt + csg_r[g];
      wsum_nxt = wsum_nxt + wsg_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r  <= 1'b0;
      w1_v_r <= 1'b0;
      w2_v_r <= 1'b0;
      w3_v_r <= 1'b0;
    end else if (en) begin
      m_v_r  <= cv[N-1];
      w1_v_r <= m_v_r;
      w2_v_r <= w1_v_r;
      w3_v_r <= w2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mask_r      <= mask_nxt;
      m_pix_r     <= fin.pix;
      m_pos_r     <= fin.pos;
      m_count_r   <= count_nxt;
      m_imp_r     <= imp_nxt;
      m_center_r  <= fin.pix[CENTER];
      prod_r      <= prod_nxt;
      wt_r        <= wt_nxt;
      w1_count_r  <= m_count_r;
      w1_imp_r    <= m_imp_r;
      w1_center_r <= m_center_r;
      csg_r       <= csg_nxt;
      wsg_r       <= wsg_nxt;
      w2_count_r  <= w1_count_r;
      w2_imp_r    <= w1_imp_r;
      w2_center_r <= w1_center_r;
      csum_r      <= csum_nxt;
      wsum_r      <= wsum_nxt;
      w3_count_r  <= w2_count_r;
      w3_imp_r    <= w2_imp_r;
      w3_center_r <= w2_center_r;
    end
  end

  // Rounded mean: (2*csum + wsum) / (2*wsum), one quotient bit per cell.
  logic           dv [9];
  pgwf_pkg::div_t dx [9];
  pgwf_pkg::div_t div_in;

  assign dv[0] = w3_v_r;
  assign dx[0] = div_in;

  always_comb begin
    div_in        = '0;
    div_in.rem    = (pgwf_pkg::NDW'(csum_r) << 1) + pgwf_pkg::NDW'(wsum_r);
    div_in.dvs    = pgwf_pkg::DW'(wsum_r) << 1;
    div_in.center = w3_center_r;
    div_in.wzero  = (wsum_r == '0);
    div_in.count  = w3_count_r;
    div_in.imp    = w3_imp_r;
  end

  for (genvar b = 0; b < 8; b++) begin : g_div
    pgwf_div_cell #(
      .BIT (7 - b)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv[b]),
      .in_div    (dx[b]),
      .out_valid (dv[b+1]),
      .out_div   (dx[b+1])
    );
  end

  // Output register; a zero weight sum passes the center pixel through.
  logic [7:0]    pixel_r;
  logic [PW-1:0] count_r;
  logic          imp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_r <= dx[8].wzero ? dx[8].center : dx[8].quo;
      count_r <= dx[8].count;
      imp_r   <= dx[8].imp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, count_r, pixel_r};
  assign out_tuser  = imp_r;

endmodule

// ----- rtl/pgwf_checker.sv -----
// Port checker of the peer group window filter and its bind to the top level.
`include "peer_group_window_filter_core_macros.svh"

module pgwf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // A held result stays offered.
  `PGWF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // With no result waiting, the input side is never blocked.
  `PGWF_ASSERT_IMPLIES(a_in_free, !out_tvalid, in_tready)

  // Every peer group holds at least one pixel and at most a full window.
  `PGWF_ASSERT_IMPLIES(a_count_range, out_tvalid,
                       (out_tdata[12:8] != 5'd0) && (out_tdata[12:8] <= 5'd25))

  // The impulse tail never spans the whole window.
  `PGWF_ASSERT_IMPLIES(a_tail_short, out_tvalid && out_tuser, out_tdata[12:8] != 5'd25)

endmodule

bind peer_group_window_filter_core pgwf_checker u_pgwf_checker (.*);

// ----- bench/peer_group_window_filter_core_tb.sv -----
// Self-checking testbench for the 3 x 3 peer group window filter core.
`timescale 1ns / 1ps

module peer_group_window_filter_core_tb;

  localparam int BLK = 3;
  localparam int NPX = BLK * BLK;
  localparam int HALF = BLK / 2;
  localparam int CTR = HALF * BLK + HALF;
  localparam int DRAIN_CYCLES = 6 * NPX + 11 + 20;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
  localparam int RANDOM_PER_PHASE = 300;

  typedef struct {
    logic [7:0] pixel;
    logic [4:0] count;
    logic       impulse;
  } filt_result_t;

  typedef struct {
    logic [199:0] window;
    bit           typed;
    filt_result_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [199:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  // Shadow copy of the register file used by the predictor.
  logic [7:0]  alpha_q = pgwf_pkg::ALPHA_RESET;
  logic [15:0] wt_q [6] = '{pgwf_pkg::W0_RESET, pgwf_pkg::W1_RESET, pgwf_pkg::W2_RESET,
                            pgwf_pkg::W4_RESET, pgwf_pkg::W5_RESET, pgwf_pkg::W8_RESET};

  filt_result_t pending_pixels[$];
  int     err_count = 0;
  longint cycle_count = 0;
  bit     long_hold_req = 1'b0;

  peer_group_window_filter_core #(.BLOCK(BLK)) u_top (.*);

  always #10 clk = ~clk;

  // Global watchdog so a hung handshake cannot stall the run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("peer_group_window_filter_core_tb: done, errors");
      $finish;
    end
  end

  // Gaussian weight of a window position, picked by its squared radius.
  function automatic longint unsigned weight_of(int p);
    int dy;
    int dx;
    dy = p / BLK - HALF;
    dx = p % BLK - HALF;
    case (dy * dy + dx * dx)
      0: return wt_q[0];
      1: return wt_q[1];
      2: return wt_q[2];
      4: return wt_q[3];
      5: return wt_q[4];
      8: return wt_q[5];
      default: return 0;
    endcase
  endfunction

  // Peer group filter: stable sort of center distances, Fisher split, gap test,
  // then the rounded weighted mean of the chosen group.
  function automatic filt_result_t filter_window(logic [199:0] win);
    longint unsigned px [NPX];
    longint unsigned dsort [NPX];
    int posn [NPX];
    longint unsigned stot, qtot, s1, q1, s2, q2, a, b, dd, nn, num, den, bnum, bden;
    longint unsigned uk, ur, csum, wsum, thr, dv, w;
    longint diff;
    logic [127:0] lhs, rhs;
    int i, j, k, best, mark, first, last;
    bit imp;
    filt_result_t r;
    stot = 0; qtot = 0; s1 = 0; q1 = 0; bnum = 0; bden = 1; best = 1; mark = -1;
    csum = 0; wsum = 0;
    thr = (alpha_q != 0) ? alpha_q : pgwf_pkg::ALPHA_FALLBACK;
    for (i = 0; i < NPX; i++) px[i] = win[i*8 +: 8];
    for (i = 0; i < NPX; i++) begin
      dv = (px[i] > px[CTR]) ? px[i] - px[CTR] : px[CTR] - px[i];
      j = i;
      while (j > 0 && dsort[j-1] > dv) begin
        dsort[j] = dsort[j-1];
        posn[j] = posn[j-1];
        j--;
      end
      dsort[j] = dv;
      posn[j] = i;
      stot += dv;
      qtot += dv * dv;
    end
    for (k = 1; k < NPX; k++) begin
      uk = k;
      ur = NPX - k;
      s1 += dsort[k-1];
      q1 += dsort[k-1] * dsort[k-1];
      s2 = stot - s1;
      q2 = qtot - q1;
      a = uk * q1 - s1 * s1;
      b = ur * q2 - s2 * s2;
      dd = a * ur + b * uk;
      diff = longint'(s1 * ur) - longint'(s2 * uk);
      nn = (diff < 0) ? -diff : diff;
      num = nn * nn;
      den = (dd != 0) ? uk * ur * dd : (uk * ur) * (uk * ur);
      lhs = {64'd0, num} * {64'd0, bden};
      rhs = {64'd0, bnum} * {64'd0, den};
      // Ties go to the later split.
      if (k == 1 || lhs >= rhs) begin
        bnum = num;
        bden = den;
        best = k;
      end
    end
    for (i = 0; i < HALF; i++)
      if (dsort[i+1] - dsort[i] > thr) mark = i;
    if (dsort[NPX-1] - dsort[NPX-2] > thr) mark = NPX - 2;
    imp = (best <= HALF) && (mark != -1) && (mark < HALF + 2);
    first = imp ? mark + 1 : 0;
    last = imp ? NPX : best;
    for (i = first; i < last; i++) begin
      w = weight_of(posn[i]);
      csum += w * px[posn[i]];
      wsum += w;
    end
    r.pixel = (wsum != 0) ? 8'((2 * csum + wsum) / (2 * wsum)) : 8'(px[CTR]);
    r.count = 5'(last - first);
    r.impulse = imp;
    return r;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pgwf_pkg::CFG_ALPHA: alpha_q = val[7:0];
      pgwf_pkg::CFG_W0:    wt_q[0] = val;
      pgwf_pkg::CFG_W1:    wt_q[1] = val;
      pgwf_pkg::CFG_W2:    wt_q[2] = val;
      pgwf_pkg::CFG_W4:    wt_q[3] = val;
      pgwf_pkg::CFG_W5:    wt_q[4] = val;
      pgwf_pkg::CFG_W8:    wt_q[5] = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] alpha, logic [15:0] w0, logic [15:0] w1,
                               logic [15:0] w2, logic [15:0] w4, logic [15:0] w5,
                               logic [15:0] w8);
    cfg_write(pgwf_pkg::CFG_ALPHA, alpha);
    cfg_write(pgwf_pkg::CFG_W0, w0);
    cfg_write(pgwf_pkg::CFG_W1, w1);
    cfg_write(pgwf_pkg::CFG_W2, w2);
    cfg_write(pgwf_pkg::CFG_W4, w4);
    cfg_write(pgwf_pkg::CFG_W5, w5);
    cfg_write(pgwf_pkg::CFG_W8, w8);
    // A write to the spare index must leave every register alone.
    cfg_write(CFG_UNUSED_IDX, 16'($urandom));
  endtask

  // Offers one window word and holds it until the core takes it. The expected
  // pixel is queued at the accepting edge, with the settings then in force.
  task automatic send_window(logic [199:0] win, bit typed, filt_result_t want);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= win;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pixels.push_back(typed ? want : filter_window(win));
    // Bursts of back-to-back words, broken by random gaps.
    if ($urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every expected pixel, then let the pipeline settle before a write.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random window: mostly a smooth patch with noise and a few impulses, some
  // fully random. Bytes beyond the 3 x 3 window are random and must not matter.
  function automatic logic [199:0] make_window();
    logic [199:0] win;
    int base, spread, i, v;
    for (i = 0; i < 25; i++) win[i*8 +: 8] = 8'($urandom);
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        // Impulse at the center over a flat patch.
        base = $urandom_range(0, 255);
        for (i = 0; i < NPX; i++) win[i*8 +: 8] = 8'(base);
        win[CTR*8 +: 8] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
      end
      default: begin
        base = $urandom_range(0, 255);
        spread = $urandom_range(0, 40);
        for (i = 0; i < NPX; i++) begin
          v = base + $urandom_range(0, 2 * spread) - spread;
          if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? 0 : 255;
          win[i*8 +: 8] = 8'((v < 0) ? 0 : (v > 255) ? 255 : v);
        end
      end
    endcase
    return win;
  endfunction

  // Receiver: picks a new stall pattern whenever the low byte of cycle_count is zero,
  // and on request holds off for a long stretch so the pipeline fills and in_tready drops.
  always @(posedge clk) begin : rx_stall
    int hold_left;
    int mode;
    if (long_hold_req && hold_left == 0) hold_left = 600;
    if (cycle_count[7:0] == 0) mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
      if (hold_left == 0) long_hold_req = 1'b0;
    end else begin
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 7) != 0);
        default: out_tready <= (cycle_count[2:0] != 0);
      endcase
    end
  end

  // Result checker: every accepted word is matched against the oldest expectation.
  always @(posedge clk) begin
    filt_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("output word with nothing expected: data %h user %b", out_tdata, out_tuser);
        err_count++;
      end else begin
        exp_r = pending_pixels.pop_front();
        if (out_tdata[7:0] !== exp_r.pixel) begin
          $error("filtered_pixel: expected %0d, got %0d", exp_r.pixel, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[12:8] !== exp_r.count) begin
          $error("peer_count: expected %0d, got %0d", exp_r.count, out_tdata[12:8]);
          err_count++;
        end
        if (out_tuser !== exp_r.impulse) begin
          $error("impulse_seen: expected %0d, got %0d", exp_r.impulse, out_tuser);
          err_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    filt_result_t none;
    logic [199:0] win;
    int ph, n, i;
    none = '{8'd0, 5'd0, 1'b0};

    // Directed windows. Flat windows have every distance zero, so the last
    // split wins and the first eight pixels average to the flat value.
    rows.push_back('{200'd0, 1'b1, '{8'd0, 5'd8, 1'b0}});
    rows.push_back('{{128'd0, {72{1'b1}}}, 1'b1, '{8'd255, 5'd8, 1'b0}});
    rows.push_back('{{200{1'b1}}, 1'b0, none});
    rows.push_back('{{128'hA5A5, {9{8'h80}}}, 1'b0, none});
    for (i = 0; i < 4; i++) begin
      // Center impulse high and low, and one stray impulse at a corner or edge.
      win = '0;
      for (n = 0; n < NPX; n++) win[n*8 +: 8] = 8'd100;
      case (i)
        0: win[CTR*8 +: 8] = 8'd255;
        1: win[CTR*8 +: 8] = 8'd0;
        2: win[0 +: 8] = 8'd255;
        default: win[8 +: 8] = 8'd0;
      endcase
      rows.push_back('{win, 1'b0, none});
    end
    for (i = 0; i < 8; i++) begin
      // Two-level windows put the split and the gap tests at varied ranks.
      win = '0;
      for (n = 0; n < NPX; n++) win[n*8 +: 8] = (n < i + 1) ? 8'd20 : 8'd230;
      rows.push_back('{win, 1'b0, none});
    end
    rows.push_back('{{{136{1'b1}}, 64'h0706050403020100}, 1'b0, none});
    rows.push_back('{{8'hFF, 192'd0} | 200'h11_22_33_44_55_66_77_88_99, 1'b0, none});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      row = rows[r];
      send_window(row.window, row.typed, row.want);
    end
    wait_idle();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;  // reset settings
        1: load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_settings(16'd255, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        3: load_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default: load_settings(16'($urandom_range(0, 64)), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom));
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 1 && n == 40) long_hold_req = 1'b1;
        send_window(make_window(), 1'b0, none);
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("peer_group_window_filter_core_tb: done, clean");
    end else begin
      $display("peer_group_window_filter_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- peer_group_window_filter_core.f -----
+incdir+rtl
rtl/pgwf_pkg.sv
rtl/pgwf_split_cell.sv
rtl/pgwf_div_cell.sv
rtl/peer_group_window_filter_core.sv
rtl/pgwf_checker.sv
bench/peer_group_window_filter_core_tb.sv
